// File: sv/cst_pkg.sv
// shared types, character codes and helpers for the character stream tokenizer
package cst_pkg;

  localparam int POS_BITS = 16;
  localparam int FLD_BITS = 16;
  localparam int MAX_TOK  = 3;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [FLD_BITS-1:0] fld_t;

  typedef enum logic [3:0] {
    TT_IDENT    = 4'd0,
    TT_INT      = 4'd1,
    TT_IF       = 4'd2,
    TT_NUMBER   = 4'd3,
    TT_OPERATOR = 4'd4,
    TT_ASSIGN   = 4'd5,
    TT_EQUAL    = 4'd6,
    TT_SEMI     = 4'd7,
    TT_LPAREN   = 4'd8,
    TT_RPAREN   = 4'd9,
    TT_LBRACE   = 4'd10,
    TT_RBRACE   = 4'd11,
    TT_ERROR    = 4'd12,
    TT_END      = 4'd13
  } tok_type_t;

  typedef enum logic [1:0] {
    WK_NONE   = 2'd0,
    WK_IDENT  = 2'd1,
    WK_NUMBER = 2'd2
  } word_kind_t;

  typedef enum logic [2:0] {
    KM_NONE = 3'd0,
    KM_I    = 3'd1,
    KM_IN   = 3'd2,
    KM_INT  = 3'd3,
    KM_IF   = 3'd4
  } kw_match_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    tok_type_t  ttype;
    fld_t       start;
    fld_t       length;
    logic [7:0] sym;
  } tok_t;

  // up to three tokens from one item, filled from entry 0
  typedef struct packed {
    tok_t [MAX_TOK-1:0] tok;
    logic [1:0]         cnt;
  } bundle_t;

  // low field bits of a position, zero extended for narrow positions
  function automatic fld_t pos_to_fld(pos_t p);
    logic [31:0] wide;
    wide = 32'(p);
    return wide[FLD_BITS-1:0];
  endfunction

endpackage

// File: sv/cst_scan.sv
// scanner state and per-item token decode
module cst_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      item_ch,
  input  logic            item_char_valid,
  input  logic            item_end,
  input  logic            take,
  output cst_pkg::bundle_t bundle
);
  import cst_pkg::*;

  pos_t       pos_r, pos_nxt;
  word_kind_t wk_r, wk_nxt;
  fld_t       ws_r, ws_nxt;
  fld_t       wl_r, wl_nxt;
  kw_match_t  km_r, km_nxt;
  logic       ap_r, ap_nxt;
  fld_t       as_r, as_nxt;
  logic       err_r, err_nxt;

  logic       is_dig, is_word, is_space;
  tok_type_t  punct;

  function automatic bundle_t push(bundle_t b, tok_t t);
    bundle_t r;
    r = b;
    unique case (b.cnt)
      2'd0:    begin r.tok[0] = t; r.cnt = 2'd1; end
      2'd1:    begin r.tok[1] = t; r.cnt = 2'd2; end
      2'd2:    begin r.tok[2] = t; r.cnt = 2'd3; end
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic tok_t word_tok(word_kind_t k, kw_match_t m, fld_t s, fld_t l);
    tok_t t;
    t.start  = s;
    t.length = l;
    t.sym    = 8'd0;
    if (k == WK_NUMBER)   t.ttype = TT_NUMBER;
    else if (m == KM_INT) t.ttype = TT_INT;
    else if (m == KM_IF)  t.ttype = TT_IF;
    else                  t.ttype = TT_IDENT;
    return t;
  endfunction

  function automatic tok_t mk_tok(tok_type_t ty, fld_t s, fld_t l, logic [7:0] c);
    tok_t t;
    t.ttype  = ty;
    t.start  = s;
    t.length = l;
    t.sym    = c;
    return t;
  endfunction

  function automatic kw_match_t next_match(kw_match_t m, logic [7:0] c);
    kw_match_t r;
    r = KM_NONE;
    if (m == KM_I && c == CH_LOW_N)       r = KM_IN;
    else if (m == KM_I && c == CH_LOW_F)  r = KM_IF;
    else if (m == KM_IN && c == CH_LOW_T) r = KM_INT;
    return r;
  endfunction

  // character classes
  always_comb begin
    is_dig   = (item_ch >= 8'h30) && (item_ch <= 8'h39);
    is_word  = is_dig || ((item_ch >= 8'h61) && (item_ch <= 8'h7A)) ||
               ((item_ch >= 8'h41) && (item_ch <= 8'h5A)) || (item_ch == CH_UNDER);
    is_space = (item_ch == CH_SPACE) || ((item_ch >= CH_TAB) && (item_ch <= CH_CR));
    unique case (item_ch)
      CH_PLUS, CH_MINUS: punct = TT_OPERATOR;
      CH_SEMI:           punct = TT_SEMI;
      CH_LPAREN:         punct = TT_LPAREN;
      CH_RPAREN:         punct = TT_RPAREN;
      CH_LBRACE:         punct = TT_LBRACE;
      CH_RBRACE:         punct = TT_RBRACE;
      default:           punct = TT_ERROR;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    wk_nxt  = wk_r;
    ws_nxt  = ws_r;
    wl_nxt  = wl_r;
    km_nxt  = km_r;
    ap_nxt  = ap_r;
    as_nxt  = as_r;
    err_nxt = err_r;
    bundle  = '0;

    if (item_char_valid && !err_r) begin
      if (is_word) begin
        // letter after a number closes the number
        if (wk_nxt == WK_NUMBER && !is_dig) begin
          bundle = push(bundle, word_tok(wk_nxt, km_nxt, ws_nxt, wl_nxt));
          wk_nxt = WK_NONE;
          wl_nxt = '0;
          km_nxt = KM_NONE;
        end
        if (wk_nxt == WK_NONE) begin
          if (ap_nxt) begin
            bundle = push(bundle, mk_tok(TT_ASSIGN, as_nxt, fld_t'(1), CH_EQ));
            ap_nxt = 1'b0;
          end
          wk_nxt = is_dig ? WK_NUMBER : WK_IDENT;
          ws_nxt = pos_to_fld(pos_r);
          wl_nxt = fld_t'(1);
          km_nxt = (item_ch == CH_LOW_I) ? KM_I : KM_NONE;
        end else begin
          if (wl_nxt != '1) wl_nxt = wl_nxt + fld_t'(1);
          km_nxt = next_match(km_nxt, item_ch);
        end
      end else begin
        if (wk_nxt != WK_NONE) begin
          bundle = push(bundle, word_tok(wk_nxt, km_nxt, ws_nxt, wl_nxt));
          wk_nxt = WK_NONE;
          wl_nxt = '0;
          km_nxt = KM_NONE;
        end
        if (is_space) begin
          // whitespace keeps a held assign
        end else if (item_ch == CH_EQ) begin
          if (ap_nxt) begin
            bundle = push(bundle, mk_tok(TT_EQUAL, as_nxt, fld_t'(2), 8'd0));
            ap_nxt = 1'b0;
          end else begin
            ap_nxt = 1'b1;
            as_nxt = pos_to_fld(pos_r);
          end
        end else begin
          if (ap_nxt) begin
            bundle = push(bundle, mk_tok(TT_ASSIGN, as_nxt, fld_t'(1), CH_EQ));
            ap_nxt = 1'b0;
          end
          bundle = push(bundle, mk_tok(punct, pos_to_fld(pos_r), fld_t'(1), item_ch));
          if (punct == TT_ERROR) err_nxt = 1'b1;
        end
      end
      pos_nxt = pos_r + pos_t'(1);
    end

    if (item_end) begin
      if (wk_nxt != WK_NONE) begin
        bundle = push(bundle, word_tok(wk_nxt, km_nxt, ws_nxt, wl_nxt));
      end
      if (ap_nxt) begin
        bundle = push(bundle, mk_tok(TT_ASSIGN, as_nxt, fld_t'(1), CH_EQ));
      end
      bundle  = push(bundle, mk_tok(TT_END, pos_to_fld(pos_nxt), '0, 8'd0));
      pos_nxt = '0;
      wk_nxt  = WK_NONE;
      ws_nxt  = '0;
      wl_nxt  = '0;
      km_nxt  = KM_NONE;
      ap_nxt  = 1'b0;
      as_nxt  = '0;
      err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      wk_r  <= WK_NONE;
      ws_r  <= '0;
      wl_r  <= '0;
      km_r  <= KM_NONE;
      ap_r  <= 1'b0;
      as_r  <= '0;
      err_r <= 1'b0;
    end else if (take) begin
      pos_r <= pos_nxt;
      wk_r  <= wk_nxt;
      ws_r  <= ws_nxt;
      wl_r  <= wl_nxt;
      km_r  <= km_nxt;
      ap_r  <= ap_nxt;
      as_r  <= as_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

// File: sv/cst_outq.sv
// result register holding one item's tokens, sent one per cycle while out_stall is low
module cst_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  cst_pkg::bundle_t bundle,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_token_type,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic [7:0]       out_symbol_char,
  output logic             out_last_of_run
);
  import cst_pkg::*;

  bundle_t    br_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       xfer, last;
  tok_t       cur;

  assign xfer  = valid_r && !out_stall;
  assign last  = (idx_r == br_r.cnt - 2'd1);
  assign ready = !valid_r || (xfer && last);

  always_comb begin
    unique case (idx_r)
      2'd1:    cur = br_r.tok[1];
      2'd2:    cur = br_r.tok[2];
      default: cur = br_r.tok[0];
    endcase
  end

  assign out_valid        = valid_r;
  assign out_token_type   = cur.ttype;
  assign out_token_start  = cur.start;
  assign out_token_length = cur.length;
  assign out_symbol_char  = cur.sym;
  assign out_last_of_run  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (xfer) begin
      if (last) valid_r <= 1'b0;
      else      idx_r   <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) br_r <= bundle;
  end

endmodule

// File: sv/char_stream_tokenizer_core.sv
// top level of the character stream tokenizer: input register, scanner, result register
// path: an item passes the input register, then moves to the result register once it is ready
// throughput: one item per cycle while each item yields at most one token and out_stall is low
// an item yielding k tokens (k up to 3) occupies the result register until all k have transferred
// reset: synchronous active-low rst_n clears scanner state and both valid flags
module char_stream_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_char_valid,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_type,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_symbol_char,
  output logic        out_last_of_run
);
  import cst_pkg::*;

  // input register
  logic       ir_valid_r;
  logic [7:0] ir_ch_r;
  logic       ir_cv_r;
  logic       ir_end_r;

  logic    q_ready;
  logic    take;
  logic    in_xfer;
  bundle_t bundle;

  // item leaves the input register when the result register can take its tokens
  assign take     = ir_valid_r && q_ready;
  // input register refills in the same cycle it empties
  assign in_stall = ir_valid_r && !q_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_valid_r <= 1'b0;
    end else if (in_xfer) begin
      ir_valid_r <= 1'b1;
    end else if (take) begin
      ir_valid_r <= 1'b0;
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ir_ch_r  <= in_ch;
      ir_cv_r  <= in_char_valid;
      ir_end_r <= in_end_of_text;
    end
  end

  // decode and scanner state update
  cst_scan u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_ch         (ir_ch_r),
    .item_char_valid (ir_cv_r),
    .item_end        (ir_end_r),
    .take            (take),
    .bundle          (bundle)
  );

  // items that yield nothing never load the result register
  cst_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (take && (bundle.cnt != 2'd0)),
    .bundle           (bundle),
    .ready            (q_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_type   (out_token_type),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_symbol_char  (out_symbol_char),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

// File: test/token_stream_checker.sv
`timescale 1ns / 100ps
// token checker: predicts the tokens of every accepted input transfer and compares result transfers
module token_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_char_valid,
  input  logic        in_end_of_text,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_token_type,
  input  logic [15:0] out_token_start,
  input  logic [15:0] out_token_length,
  input  logic [7:0]  out_symbol_char,
  input  logic        out_last_of_run,
  output int          mismatch_count,
  output int          tokens_waiting,
  output int          tokens_checked,
  output int          items_taken
);
  import cst_pkg::*;

  typedef struct packed {
    tok_type_t  ttype;
    fld_t       start;
    fld_t       length;
    logic [7:0] sym;
    logic       last;
  } tok_exp_t;

  tok_exp_t   expected_toks[$];
  tok_exp_t   item_toks[$];

  // scanner copy
  pos_t       position;
  word_kind_t word_kind;
  fld_t       word_start;
  fld_t       word_length;
  kw_match_t  kw_state;
  logic       assign_held;
  fld_t       assign_at;
  logic       error_seen;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_scan();
    position    = '0;
    word_kind   = WK_NONE;
    word_start  = '0;
    word_length = '0;
    kw_state    = KM_NONE;
    assign_held = 1'b0;
    assign_at   = '0;
    error_seen  = 1'b0;
  endtask

  task automatic add_token(tok_type_t t, fld_t start, fld_t len, logic [7:0] sym);
    tok_exp_t e;
    e.ttype  = t;
    e.start  = start;
    e.length = len;
    e.sym    = sym;
    e.last   = 1'b0;
    item_toks.insert(item_toks.size(), e);
  endtask

  task automatic close_word();
    tok_type_t t;
    if (word_kind != WK_NONE) begin
      t = TT_IDENT;
      if (word_kind == WK_NUMBER) t = TT_NUMBER;
      else if (kw_state == KM_INT) t = TT_INT;
      else if (kw_state == KM_IF) t = TT_IF;
      add_token(t, word_start, word_length, 8'h00);
      word_kind   = WK_NONE;
      word_length = '0;
      kw_state    = KM_NONE;
    end
  endtask

  task automatic release_assign();
    if (assign_held) begin
      assign_held = 1'b0;
      add_token(TT_ASSIGN, assign_at, 16'd1, CH_EQ);
    end
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic cv, input logic eot);
    tok_type_t t;
    tok_exp_t  e;
    logic      word_ch;
    item_toks.delete();
    if (cv && !error_seen) begin
      word_ch = is_digit(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                c == CH_UNDER;
      if (word_ch) begin
        if (word_kind == WK_NUMBER && !is_digit(c)) close_word();
        if (word_kind == WK_NONE) begin
          release_assign();
          word_kind   = is_digit(c) ? WK_NUMBER : WK_IDENT;
          word_start  = fld_t'(position);
          word_length = 16'd1;
          kw_state    = (c == CH_LOW_I) ? KM_I : KM_NONE;
        end else begin
          if (word_length != 16'hFFFF) word_length = word_length + 16'd1;
          if (kw_state == KM_I && c == CH_LOW_N) kw_state = KM_IN;
          else if (kw_state == KM_I && c == CH_LOW_F) kw_state = KM_IF;
          else if (kw_state == KM_IN && c == CH_LOW_T) kw_state = KM_INT;
          else kw_state = KM_NONE;
        end
      end else begin
        close_word();
        if (c == CH_EQ) begin
          if (assign_held) begin
            add_token(TT_EQUAL, assign_at, 16'd2, 8'h00);
            assign_held = 1'b0;
          end else begin
            assign_held = 1'b1;
            assign_at   = fld_t'(position);
          end
        end else if (c != CH_SPACE && !(c >= CH_TAB && c <= CH_CR)) begin
          case (c)
            CH_PLUS, CH_MINUS: t = TT_OPERATOR;
            CH_SEMI:           t = TT_SEMI;
            CH_LPAREN:         t = TT_LPAREN;
            CH_RPAREN:         t = TT_RPAREN;
            CH_LBRACE:         t = TT_LBRACE;
            CH_RBRACE:         t = TT_RBRACE;
            default:           t = TT_ERROR;
          endcase
          release_assign();
          add_token(t, fld_t'(position), 16'd1, c);
          if (t == TT_ERROR) error_seen = 1'b1;
        end
      end
      position = position + pos_t'(1);
    end
    if (eot) begin
      close_word();
      release_assign();
      add_token(TT_END, fld_t'(position), 16'd0, 8'h00);
      clear_scan();
    end
    if (item_toks.size() > 0) begin
      e = item_toks.pop_back();
      e.last = 1'b1;
      item_toks.insert(item_toks.size(), e);
    end
    foreach (item_toks[i]) expected_toks.insert(expected_toks.size(), item_toks[i]);
  endtask

  task automatic report(string field, int exp_val, int act_val);
    mismatch_count++;
    $error("%s expected %0d got %0d", field, exp_val, act_val);
  endtask

  always @(posedge clk) begin : watch
    tok_exp_t e;
    if (!rst_n) begin
      clear_scan();
      expected_toks.delete();
      mismatch_count = 0;
      tokens_checked = 0;
      items_taken    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_toks.size() == 0) begin
          mismatch_count++;
          $error("token transfer with nothing expected: type %0d start %0d",
                 out_token_type, out_token_start);
        end else begin
          e = expected_toks.pop_front();
          tokens_checked++;
          if (out_token_type !== e.ttype)
            report("token_type", e.ttype, out_token_type);
          if (out_token_start !== e.start)
            report("token_start", e.start, out_token_start);
          if (out_token_length !== e.length)
            report("token_length", e.length, out_token_length);
          if (out_symbol_char !== e.sym)
            report("symbol_char", e.sym, out_symbol_char);
          if (out_last_of_run !== e.last)
            report("last_of_run", e.last, out_last_of_run);
        end
      end
      if (in_valid && !in_stall) begin
        predict_tokens(in_ch, in_char_valid, in_end_of_text);
        items_taken++;
      end
    end
    tokens_waiting = expected_toks.size();
  end

endmodule

// File: test/tb_char_stream_tokenizer_core.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, character stimulus and verdict for the tokenizer core
module tb_char_stream_tokenizer_core;
  import cst_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 370;
  localparam int CALM_ITEMS   = 80;     // tail of the random part with no idling at all
  localparam int HOLD_CYCLES  = 80;     // long receiver hold-off

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch          = 8'h00;
  logic        in_char_valid  = 1'b0;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [3:0]  out_token_type;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [7:0]  out_symbol_char;
  logic        out_last_of_run;

  int mismatch_count;
  int tokens_waiting;
  int tokens_checked;
  int items_taken;
  int cycle_count = 0;
  int items_sent  = 0;

  // idling switches for each side, and the handshake for the long receiver hold-off
  logic send_idle   = 1'b0;
  logic recv_idle   = 1'b0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  // set once a random byte went in; if it is no valid character the block ignores the rest of that text
  logic text_broken = 1'b0;

  // letters and underscore at 0..52, digits at 53..62
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  char_stream_tokenizer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_char_valid    (in_char_valid),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_type   (out_token_type),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_symbol_char  (out_symbol_char),
    .out_last_of_run  (out_last_of_run)
  );

  token_stream_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_char_valid    (in_char_valid),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_type   (out_token_type),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_symbol_char  (out_symbol_char),
    .out_last_of_run  (out_last_of_run),
    .mismatch_count   (mismatch_count),
    .tokens_waiting   (tokens_waiting),
    .tokens_checked   (tokens_checked),
    .items_taken      (items_taken)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_char_stream_tokenizer_core: errors");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // hold the result side while the sender keeps offering transfers
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one input transfer; called at a falling edge and returns at a falling edge
  task automatic send_item(input logic [7:0] c, input logic cv, input logic eot);
    int gap;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_ch          <= c;
    in_char_valid  <= cv;
    in_end_of_text <= eot;
    // the transfer completes at the first rising edge without stall
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!text_broken && (cv || eot)) items_sent++;
    if (eot) text_broken = 1'b0;
  endtask

  task automatic send_chars(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, 1'b0);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 5))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return 8'h0A;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 6))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_SEMI;
      3:       return CH_LPAREN;
      4:       return CH_RPAREN;
      5:       return CH_LBRACE;
      default: return CH_RBRACE;
    endcase
  endfunction

  // stop offering and wait until every predicted token has been seen
  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_waiting != 0) @(negedge clk);
    // a trailing item may produce nothing; give the pipeline time to settle
    repeat (6) @(negedge clk);
  endtask

  // one lexical piece of well-formed text, or now and then some noise
  task automatic send_fragment();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        // identifier
        send_item(word_chars[$urandom_range(0, 52)], 1'b1, 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) send_item(word_chars[$urandom_range(0, 62)], 1'b1, 1'b0);
      end
      3: send_chars("int");
      4: send_chars("if");
      5: begin
        // words that only start like a keyword
        case ($urandom_range(0, 4))
          0:       send_chars("i");
          1:       send_chars("in");
          2:       send_chars("intx");
          3:       send_chars("if_");
          default: send_chars("int9");
        endcase
      end
      6, 7: begin
        n = $urandom_range(1, 5);
        repeat (n) send_item(word_chars[53 + $urandom_range(0, 9)], 1'b1, 1'b0);
      end
      8: begin
        // number running into a letter splits into number and identifier
        n = $urandom_range(1, 3);
        repeat (n) send_item(word_chars[53 + $urandom_range(0, 9)], 1'b1, 1'b0);
        send_item(word_chars[$urandom_range(0, 52)], 1'b1, 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) send_item(word_chars[$urandom_range(0, 62)], 1'b1, 1'b0);
      end
      9, 10: send_item(CH_EQ, 1'b1, 1'b0);
      11: begin
        send_item(CH_EQ, 1'b1, 1'b0);
        send_item(CH_EQ, 1'b1, 1'b0);
      end
      12: begin
        // equal split by whitespace
        send_item(CH_EQ, 1'b1, 1'b0);
        n = $urandom_range(1, 3);
        repeat (n) send_item(pick_space(), 1'b1, 1'b0);
        send_item(CH_EQ, 1'b1, 1'b0);
      end
      13, 14, 15, 16: send_item(pick_punct(), 1'b1, 1'b0);
      17, 18: send_item(pick_space(), 1'b1, 1'b0);
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          // empty item, the block takes it and does nothing
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else begin
          send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
          text_broken = 1'b1;
        end
      end
    endcase
    if ($urandom_range(0, 1) == 0) send_item(pick_space(), 1'b1, 1'b0);
  endtask

  // a short random source text closed by the end flag
  task automatic send_text();
    int frags;
    frags = $urandom_range(1, 14);
    repeat (frags) send_fragment();
    case ($urandom_range(0, 3))
      0:       send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      1:       send_item(word_chars[$urandom_range(0, 62)], 1'b1, 1'b1);
      2:       send_item(pick_punct(), 1'b1, 1'b1);
      default: send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endcase
  endtask

  initial begin
    // hold reset low at the start, then release it
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: keywords and parens, equal across a tab, number then letter,
    // held assign released by a brace, word flushed by a combined char and end
    send_idle = 1'b1;
    recv_idle = 1'b1;
    send_chars("int(if)");
    send_item(CH_EQ, 1'b1, 1'b0);
    send_item(CH_TAB, 1'b1, 1'b0);
    send_item(CH_EQ, 1'b1, 1'b0);
    send_chars("9_={-};");
    send_item("0", 1'b1, 1'b1);
    // NUL after an open word, an ignored letter, then an end-only transfer
    send_chars("a");
    send_item(8'h00, 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(8'hAA, 1'b0, 1'b0);
    // top byte after a held assign; high byte with end is ignored but ends the text
    send_item(CH_EQ, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    drain();

    // back pressure: the result side holds off while we keep offering
    send_idle = 1'b0;
    hold_req  = 1'b1;
    while (!hold_done) begin
      send_item(CH_PLUS, 1'b1, 1'b0);
      send_item("x", 1'b1, 1'b0);
    end
    send_item(CH_SEMI, 1'b1, 1'b1);
    drain();

    // random texts; idling switched per text, none in the tail
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else begin
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      send_text();
    end
    drain();

    $display("covered %0d input transfers and %0d checked tokens", items_taken, tokens_checked);
    $display("incl. keywords, split equal, errors, empty items, back pressure, idle bursts");
    if (mismatch_count == 0 && tokens_waiting == 0) begin
      $display("tb_char_stream_tokenizer_core: clean");
    end else begin
      $display("tb_char_stream_tokenizer_core: errors");
    end
    $finish;
  end

endmodule

// File: char_stream_tokenizer_core.f
sv/cst_pkg.sv
sv/cst_scan.sv
sv/cst_outq.sv
sv/char_stream_tokenizer_core.sv
test/token_stream_checker.sv
test/tb_char_stream_tokenizer_core.sv
